// ----- rtl/mpfd_pkg.sv -----
package mpfd_pkg;

   // Internal coordinate width: an 11-bit origin plus an 11-bit extent, with headroom.
   localparam int CW = 13;

   localparam logic [7:0] BYTE_ON  = 8'hFF;
   localparam logic [7:0] BYTE_OFF = 8'h00;

   localparam logic [7:0] PANEL_WIDTH_RESET  = 8'd128;
   localparam logic [6:0] PANEL_HEIGHT_RESET = 7'd64;

   localparam logic REG_PANEL_WIDTH  = 1'b0;
   localparam logic REG_PANEL_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_OUTLINE = 2'd1,
      FUNC_FILL    = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   // Rectangle that the drawing engine sweeps next.
   typedef enum logic [2:0] {
      RECT_FULL,
      RECT_TOP,
      RECT_BOTTOM,
      RECT_LEFT,
      RECT_RIGHT
   } rect_sel_type;

   typedef struct packed {
      logic         capture;
      logic         clr_step;
      logic         clr_init;
      logic         rect_load;
      rect_sel_type rect_sel;
      logic         rect_rd;
      logic         rect_wr;
      logic         rd_issue;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     draw_ok;
      logic     clr_last;
      logic     rect_empty;
      logic     rect_last;
   } status_type;

endpackage

// ----- rtl/mpfd_csr.sv -----
module mpfd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  panel_width,
   output logic [6:0]  panel_height
);
   import mpfd_pkg::*;

   logic [7:0] panel_width_ff, panel_width_in;
   logic [6:0] panel_height_ff, panel_height_in;
   logic       wr_en;
   logic       reg_index;

   assign reg_index = paddr[2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      panel_width_in  = panel_width_ff;
      panel_height_in = panel_height_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_PANEL_WIDTH:  panel_width_in  = pwdata[7:0];
            REG_PANEL_HEIGHT: panel_height_in = pwdata[6:0];
            default:          panel_width_in  = panel_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= PANEL_WIDTH_RESET;
         panel_height_ff <= PANEL_HEIGHT_RESET;
      end else begin
         panel_width_ff  <= panel_width_in;
         panel_height_ff <= panel_height_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PANEL_WIDTH:  prdata = {24'd0, panel_width_ff};
         REG_PANEL_HEIGHT: prdata = {25'd0, panel_height_ff};
         default:          prdata = 32'd0;
      endcase
   end

   assign pready       = 1'b1;
   assign panel_width  = panel_width_ff;
   assign panel_height = panel_height_ff;

endmodule

// ----- rtl/mpfd_datapath.sv -----
module mpfd_datapath #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mpfd_pkg::cmd_type      cmd,
   output mpfd_pkg::status_type   status,
   input  logic [7:0]             panel_width,
   input  logic [6:0]             panel_height,
   input  logic [1:0]             req_func,
   input  logic signed [10:0]     req_pos_x,
   input  logic signed [10:0]     req_pos_y,
   input  logic signed [10:0]     req_rect_width,
   input  logic signed [10:0]     req_rect_height,
   input  logic                   req_ink,
   input  logic [9:0]             req_read_index,
   output logic [7:0]             rsp_read_data,
   output logic                   rsp_was_read
);
   import mpfd_pkg::*;

   localparam int PAGES       = (MAX_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = MAX_WIDTH * PAGES;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam logic signed [CW-1:0] ONE  = CW'(1);
   localparam logic signed [CW-1:0] ZERO = CW'(0);

   // Captured request.
   func_type          func_ff;
   logic signed [10:0] x_ff, y_ff, w_ff, h_ff;
   logic              color_ff;
   logic [9:0]        ridx_ff;

   // Frame store with one write port and one registered read port.
   logic [7:0]    store_ff [STORE_BYTES];
   logic [7:0]    rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   // Effective panel size.
   logic [8:0] ew;
   logic [7:0] eh;

   // Clear sweep.
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW:0]   clr_next, clr_limit;
   logic [16:0]   area_bytes;
   logic          clr_we, clr_last;

   // Rectangle sweep registers.
   logic [8:0] cx_ff, cx_in, cx0_ff, cxl_ff;
   logic [7:0] cy0_ff, cy1_ff;
   logic [3:0] pg_ff, pg_in, pgl_ff;
   logic       empty_ff;

   logic signed [CW-1:0] xs, ys, ws, hs, rx, ry, rw, rh;
   logic signed [CW-1:0] lox, loy, hix, hiy, hix_m1, hiy_m1, ewc, ehc;
   logic [12:0]          addr_full;
   logic [AW-1:0]        rect_addr;
   logic [7:0]           mask, rect_wdata;
   logic [6:0]           row;
   logic                 rect_last, rd_in_range;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func_type'(req_func);
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         w_ff     <= req_rect_width;
         h_ff     <= req_rect_height;
         color_ff <= req_ink;
         ridx_ff  <= req_read_index;
      end
   end

   assign ew = ({1'b0, panel_width} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, panel_width};
   assign eh = ({1'b0, panel_height} > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, panel_height};

   // Clear covers the first width*height/8 bytes in address order; the byte count rounds down.
   assign area_bytes = (17'(ew) * 17'(eh)) >> 3;
   assign clr_limit  = cmd.clr_init ? (AW+1)'(STORE_BYTES) : area_bytes[AW:0];
   assign clr_next   = {1'b0, clr_addr_ff} + (AW+1)'(1);
   assign clr_last   = clr_next >= clr_limit;
   assign clr_we     = cmd.clr_step && ({1'b0, clr_addr_ff} < clr_limit);

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_step) begin
         clr_addr_in = clr_last ? '0 : clr_next[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // An outline is swept as four thin rectangles, one per edge.
   assign xs = $signed({{(CW-11){x_ff[10]}}, x_ff});
   assign ys = $signed({{(CW-11){y_ff[10]}}, y_ff});
   assign ws = $signed({{(CW-11){w_ff[10]}}, w_ff});
   assign hs = $signed({{(CW-11){h_ff[10]}}, h_ff});

   always_comb begin
      rx = xs;
      ry = ys;
      rw = ws;
      rh = hs;
      case (cmd.rect_sel)
         RECT_TOP:    rh = ONE;
         RECT_BOTTOM: begin
            ry = ys + hs - ONE;
            rh = ONE;
         end
         RECT_LEFT:   rw = ONE;
         RECT_RIGHT:  begin
            rx = xs + ws - ONE;
            rw = ONE;
         end
         default:     rw = ws;
      endcase
   end

   assign ewc    = $signed({(CW-9)'(0), ew});
   assign ehc    = $signed({(CW-8)'(0), eh});
   assign lox    = (rx < ZERO) ? ZERO : rx;
   assign loy    = (ry < ZERO) ? ZERO : ry;
   assign hix    = ((rx + rw) > ewc) ? ewc : (rx + rw);
   assign hiy    = ((ry + rh) > ehc) ? ehc : (ry + rh);
   assign hix_m1 = hix - ONE;
   assign hiy_m1 = hiy - ONE;

   assign rect_last = (cx_ff == cxl_ff) && (pg_ff == pgl_ff);

   always_comb begin
      cx_in = cx_ff;
      pg_in = pg_ff;
      if (cmd.rect_load) begin
         cx_in = lox[8:0];
         pg_in = loy[6:3];
      end else if (cmd.rect_wr) begin
         if (cx_ff == cxl_ff) begin
            cx_in = cx0_ff;
            pg_in = pg_ff + 4'd1;
         end else begin
            cx_in = cx_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      pg_ff <= pg_in;
      if (cmd.rect_load) begin
         cx0_ff   <= lox[8:0];
         cxl_ff   <= hix_m1[8:0];
         cy0_ff   <= loy[7:0];
         cy1_ff   <= hiy[7:0];
         pgl_ff   <= hiy_m1[6:3];
         empty_ff <= (lox >= hix) || (loy >= hiy);
      end
   end

   assign addr_full = {9'd0, pg_ff} * {4'd0, ew} + {4'd0, cx_ff};
   assign rect_addr = addr_full[AW-1:0];

   always_comb begin
      mask = '0;
      row  = '0;
      for (int i = 0; i < 8; i++) begin
         row     = {pg_ff, 3'(i)};
         mask[i] = ({1'b0, row} >= cy0_ff) && ({1'b0, row} < cy1_ff);
      end
   end

   assign rect_wdata = color_ff ? (rd_data_ff | mask) : (rd_data_ff & ~mask);

   assign mem_we    = clr_we || cmd.rect_wr;
   assign mem_waddr = cmd.clr_step ? clr_addr_ff : rect_addr;
   assign mem_wdata = cmd.clr_step ? ((color_ff && !cmd.clr_init) ? BYTE_ON : BYTE_OFF)
                                   : rect_wdata;
   assign mem_re    = cmd.rect_rd || cmd.rd_issue;
   assign mem_raddr = cmd.rd_issue ? AW'(ridx_ff) : rect_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_raddr];
      end
   end

   assign rd_in_range = {22'd0, ridx_ff} < 32'(STORE_BYTES);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_was_read  <= (func_ff == FUNC_READ);
         rsp_read_data <= ((func_ff == FUNC_READ) && rd_in_range) ? rd_data_ff : BYTE_OFF;
      end
   end

   assign status.func       = func_ff;
   assign status.draw_ok    = (w_ff > 11'sd0) && (h_ff > 11'sd0);
   assign status.clr_last   = clr_last;
   assign status.rect_empty = empty_ff;
   assign status.rect_last  = rect_last;

endmodule

// ----- rtl/mpfd_ctrl.sv -----
module mpfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mpfd_pkg::cmd_type    cmd,
   input  mpfd_pkg::status_type status
);
   import mpfd_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_CLEAR,
      S_SETUP,
      S_RMW_RD,
      S_RMW_WR,
      S_RDMEM,
      S_RESP
   } state_type;

   state_type    state_ff, state_in;
   rect_sel_type sel_ff, sel_in, sel_next;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         sub_done;

   // Edge order of an outline; a fill is a single rectangle.
   always_comb begin
      sub_done = 1'b0;
      sel_next = sel_ff;
      case (sel_ff)
         RECT_TOP:    sel_next = RECT_BOTTOM;
         RECT_BOTTOM: sel_next = RECT_LEFT;
         RECT_LEFT:   sel_next = RECT_RIGHT;
         default:     sub_done = 1'b1;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rect_sel = sel_ff;
      state_in     = state_ff;
      sel_in       = sel_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            cmd.clr_init = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.func)
               FUNC_CLEAR: state_in = S_CLEAR;
               FUNC_OUTLINE: begin
                  sel_in   = RECT_TOP;
                  state_in = status.draw_ok ? S_SETUP : S_RESP;
               end
               FUNC_FILL: begin
                  sel_in   = RECT_FULL;
                  state_in = status.draw_ok ? S_SETUP : S_RESP;
               end
               FUNC_READ: state_in = S_RDMEM;
               default:   state_in = S_RESP;
            endcase
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_RESP;
            end
         end
         S_SETUP: begin
            cmd.rect_load = 1'b1;
            state_in      = S_RMW_RD;
         end
         S_RMW_RD: begin
            if (status.rect_empty) begin
               sel_in   = sel_next;
               state_in = sub_done ? S_RESP : S_SETUP;
            end else begin
               cmd.rect_rd = 1'b1;
               state_in    = S_RMW_WR;
            end
         end
         S_RMW_WR: begin
            cmd.rect_wr = 1'b1;
            if (status.rect_last) begin
               sel_in   = sel_next;
               state_in = sub_done ? S_RESP : S_SETUP;
            end else begin
               state_in = S_RMW_RD;
            end
         end
         S_RDMEM: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sel_ff       <= RECT_FULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a result is still waiting");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW_WR) |-> ($past(state_ff) == S_RMW_RD))
      else $error("read-modify-write without a preceding read");

   a_write_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW_WR) |-> !status.rect_empty)
      else $error("byte written for a rectangle that clips to nothing");

endmodule

// ----- rtl/mono_page_framebuffer_draw.sv -----
// Channel    Direction  Handshake                      Payload
// request    in         req_valid / req_stall           req_func .. req_read_index
// response   out        rsp_valid / rsp_stall           rsp_read_data, rsp_was_read
// registers  in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A read passes through dispatch and a store read before the response register loads;
// a clear writes n = width*height/8 bytes. A fill, or each outline edge, takes a setup
// step plus a read and then a write per touched byte, or no store access if clipped
// away, between dispatch and response. After reset the whole store, MAX_WIDTH *
// ceil(MAX_HEIGHT/8) bytes (1024 by default), is swept to zero with req_stall high.
// The response register holds one result; the next waits until it is taken.
module mono_page_framebuffer_draw #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [10:0] req_pos_x,
   input  logic signed [10:0] req_pos_y,
   input  logic signed [10:0] req_rect_width,
   input  logic signed [10:0] req_rect_height,
   input  logic               req_ink,
   input  logic [9:0]         req_read_index,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_was_read,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import mpfd_pkg::*;

   // Controller and datapath talk only through these two bundles.
   cmd_type    cmd;
   status_type status;

   logic [7:0] panel_width;
   logic [6:0] panel_height;

   // Panel size registers. The user must make writes land only while the block is idle;
   // the block does not enforce this, and the datapath reads them directly.
   mpfd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .panel_width  (panel_width),
      .panel_height (panel_height)
   );

   // The controller sequences the reset sweep, clears, rectangle sweeps and reads,
   // and owns the response valid flag.
   mpfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the frame store, the clipping arithmetic, the byte
   // masks and the response payload register.
   mpfd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .panel_width     (panel_width),
      .panel_height    (panel_height),
      .req_func        (req_func),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_ink         (req_ink),
      .req_read_index  (req_read_index),
      .rsp_read_data   (rsp_read_data),
      .rsp_was_read    (rsp_was_read)
   );

endmodule
